// ===== rtl/core/tpds_pkg.sv =====
// ----------------------------------------------------------------------------
// tpds_pkg
// Shared constants and controller/datapath interface types for the two-pass
// peak-decay bar smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package tpds_pkg;

	localparam int MAX_BARS   = 64;
	localparam int BAR_AW     = $clog2(MAX_BARS);
	localparam int LEVEL_W    = 16;
	localparam int CNT_W      = BAR_AW + 1;
	localparam int OUT_DATA_W = 24;

	// Decay to about two thirds: (x * 43691) >> 16, truncating.
	localparam logic [LEVEL_W-1:0] DECAY_MUL   = 16'd43691;
	localparam int                 DECAY_SHIFT = 16;

	localparam logic [CNT_W-1:0] NUM_BARS_RESET = 7'd32;
	localparam logic [CNT_W-1:0] NUM_BARS_MAX   = 7'(MAX_BARS);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              raw_we;
		logic [BAR_AW-1:0] raw_waddr;
		logic [BAR_AW-1:0] addr;
		logic              pass_init;
		logic              fwd_step;
		logic              bwd_step;
		logic              out_load;
		logic              out_last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic differs;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/two_pass_peak_decay_smoother.sv =====
// ----------------------------------------------------------------------------
// two_pass_peak_decay_smoother
// Collects a frame of bar levels, smooths it with a forward and a backward
// peak-decay pass, and emits the frame when it differs from the last one.
//
// Channels: s_axis takes one raw bar level per transfer, in frame order.
// m_axis delivers one smoothed bar per transfer with its index; tlast marks
// the final bar of an emitted frame. cfg writes the bar count (0 acts as 1,
// values above 64 act as 64); a write also restarts frame loading and forces
// the next frame to be emitted. Write it only while the block is idle.
// Flow: bars are stored as they arrive. After the final bar of a frame, each
// pass visits every bar with a read state and then a decay multiply and write
// state, over the single-port frame memories. Emission then reads each bar and
// loads it into the output register when that is free. While a frame is being
// emitted, the non-final bars of the next frame are still taken.
// Reset: bar count 32, previous frame all zeros, nothing emitted yet; no
// memory clearing pass is needed. A stalled m_axis holds the current bar in
// the output register and pauses emission.
// ----------------------------------------------------------------------------
`default_nettype none

module two_pass_peak_decay_smoother (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [tpds_pkg::LEVEL_W-1:0]       s_axis_tdata,  // [15:0] bar_level
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [15:0] smoothed_level, [21:16] bar_index, [23:22] zero
	output logic [tpds_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	output logic                                    m_axis_tlast,  // last_bar
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [tpds_pkg::CNT_W-1:0]         cfg_data       // num_bars
);

	tpds_pkg::cmd_t cmd;
	tpds_pkg::sts_t sts;

	tpds_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts)
	);

	tpds_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_level      (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/core/tpds_dpath.sv =====
// ----------------------------------------------------------------------------
// tpds_dpath
// Frame memories, decay carry, frame compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpds_dpath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tpds_pkg::cmd_t                    cmd,
	output tpds_pkg::sts_t                         sts,
	input  wire logic [tpds_pkg::LEVEL_W-1:0]      in_level,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [tpds_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	output logic                                   m_axis_tlast
);

	logic [tpds_pkg::LEVEL_W-1:0] raw_mem  [tpds_pkg::MAX_BARS];
	logic [tpds_pkg::LEVEL_W-1:0] fwd_mem  [tpds_pkg::MAX_BARS];
	logic [tpds_pkg::LEVEL_W-1:0] prev_mem [tpds_pkg::MAX_BARS];
	logic [tpds_pkg::MAX_BARS-1:0] prev_vld_q;

	logic [tpds_pkg::LEVEL_W-1:0] raw_rd_q;
	logic [tpds_pkg::LEVEL_W-1:0] fwd_rd_q;
	logic [tpds_pkg::LEVEL_W-1:0] prev_rd_q;
	logic                         prev_vld_rd_q;

	logic [tpds_pkg::LEVEL_W-1:0] carry_q;
	logic                         differs_q;

	logic                          out_vld_q;
	logic [tpds_pkg::LEVEL_W-1:0]  out_level_q;
	logic [tpds_pkg::BAR_AW-1:0]   out_index_q;
	logic                          out_last_q;

	logic [2*tpds_pkg::LEVEL_W-1:0] prod;
	logic [tpds_pkg::LEVEL_W-1:0]   decayed;
	logic [tpds_pkg::LEVEL_W-1:0]   carry_next;
	logic [tpds_pkg::LEVEL_W-1:0]   smoothed;
	logic [tpds_pkg::LEVEL_W-1:0]   prev_val;
	logic                           bar_differs;

	always_comb begin
		prod        = 32'(carry_q) * 32'(tpds_pkg::DECAY_MUL);
		decayed     = prod[tpds_pkg::DECAY_SHIFT +: tpds_pkg::LEVEL_W];
		carry_next  = (raw_rd_q > decayed) ? raw_rd_q : decayed;
		smoothed    = (fwd_rd_q > carry_next) ? fwd_rd_q : carry_next;
		prev_val    = prev_vld_rd_q ? prev_rd_q : '0;
		bar_differs = cmd.bwd_step && (smoothed != prev_val);
	end

	// Raw frame: written while loading, read by both passes.
	always_ff @(posedge clk) begin
		if (cmd.raw_we) begin
			raw_mem[cmd.raw_waddr] <= in_level;
		end
		raw_rd_q <= raw_mem[cmd.addr];
	end

	// Forward results; the backward pass overwrites each entry with the smoothed bar.
	always_ff @(posedge clk) begin
		if (cmd.fwd_step) begin
			fwd_mem[cmd.addr] <= carry_next;
		end else if (cmd.bwd_step) begin
			fwd_mem[cmd.addr] <= smoothed;
		end
		fwd_rd_q <= fwd_mem[cmd.addr];
	end

	// Previous emitted frame; entries never written read as zero.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			prev_mem[cmd.addr] <= fwd_rd_q;
		end
		prev_rd_q <= prev_mem[cmd.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_vld_q    <= '0;
			prev_vld_rd_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				prev_vld_q[cmd.addr] <= 1'b1;
			end
			prev_vld_rd_q <= prev_vld_q[cmd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q   <= '0;
			differs_q <= 1'b0;
		end else if (cmd.pass_init) begin
			carry_q   <= '0;
			differs_q <= 1'b0;
		end else if (cmd.fwd_step || cmd.bwd_step) begin
			carry_q   <= carry_next;
			differs_q <= differs_q | bar_differs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_level_q <= fwd_rd_q;
			out_index_q <= cmd.addr;
			out_last_q  <= cmd.out_last;
		end
	end

	assign sts.differs  = differs_q | bar_differs;
	assign sts.out_free = !out_vld_q || m_axis_tready;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_index_q, out_level_q};
	assign m_axis_tlast  = out_last_q;

	a_pass_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.fwd_step && cmd.bwd_step))
		else $error("forward and backward step at once");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_vld_q || m_axis_tready))
		else $error("output register overwritten before transfer");

	a_load_during_pass: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(cmd.fwd_step || cmd.bwd_step || cmd.pass_init))
		else $error("emission overlaps a smoothing pass");

endmodule

`default_nettype wire

// ===== rtl/core/tpds_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpds_ctrl
// Sequencer for loading, forward pass, backward pass and frame emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tpds_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tpds_pkg::CNT_W-1:0]      cfg_data,
	output tpds_pkg::cmd_t                       cmd,
	input  wire tpds_pkg::sts_t                  sts
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_FWD_RD    = 7'b0000010,
		ST_FWD_WR    = 7'b0000100,
		ST_BWD_RD    = 7'b0001000,
		ST_BWD_WR    = 7'b0010000,
		ST_EMIT_RD   = 7'b0100000,
		ST_EMIT_WAIT = 7'b1000000
	} state_t;

	state_t                      state_q, state_d;
	logic [tpds_pkg::CNT_W-1:0]  n_q;
	logic [tpds_pkg::BAR_AW-1:0] fill_q;
	logic [tpds_pkg::BAR_AW-1:0] idx_q, idx_d;
	logic                        emitted_q;
	logic [tpds_pkg::BAR_AW-1:0] last_idx;
	logic                        emitting;
	logic                        in_xfer;
	logic                        cfg_xfer;
	logic                        frame_done;
	logic                        emit_start;
	logic [tpds_pkg::CNT_W-1:0]  n_new;

	assign last_idx = tpds_pkg::BAR_AW'(n_q - 7'd1);
	assign emitting = (state_q == ST_EMIT_RD) || (state_q == ST_EMIT_WAIT);

	// Non-final bars of the next frame may load while the current one is emitted.
	assign s_axis_tready = ((state_q == ST_IDLE) && !cfg_valid)
	                       || (emitting && (fill_q != last_idx));
	assign cfg_ready     = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cfg_xfer      = cfg_valid && cfg_ready;
	assign frame_done    = in_xfer && (fill_q == last_idx);

	always_comb begin
		if (cfg_data == '0) begin
			n_new = 7'd1;
		end else if (cfg_data > tpds_pkg::NUM_BARS_MAX) begin
			n_new = tpds_pkg::NUM_BARS_MAX;
		end else begin
			n_new = cfg_data;
		end
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		emit_start = 1'b0;
		cmd        = '0;
		cmd.raw_we    = in_xfer;
		cmd.raw_waddr = fill_q;
		cmd.addr      = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (frame_done) begin
					cmd.pass_init = 1'b1;
					idx_d         = '0;
					state_d       = ST_FWD_RD;
				end
			end
			ST_FWD_RD: begin
				state_d = ST_FWD_WR;
			end
			ST_FWD_WR: begin
				cmd.fwd_step = 1'b1;
				if (idx_q == last_idx) begin
					// The backward pass starts again from a zero carry.
					cmd.pass_init = 1'b1;
					state_d       = ST_BWD_RD;
				end else begin
					idx_d   = idx_q + 6'd1;
					state_d = ST_FWD_RD;
				end
			end
			ST_BWD_RD: begin
				state_d = ST_BWD_WR;
			end
			ST_BWD_WR: begin
				cmd.bwd_step = 1'b1;
				if (idx_q == '0) begin
					if (sts.differs || !emitted_q) begin
						emit_start = 1'b1;
						state_d    = ST_EMIT_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					idx_d   = idx_q - 6'd1;
					state_d = ST_BWD_RD;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = (idx_q == last_idx);
					if (idx_q == last_idx) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_q + 6'd1;
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			fill_q    <= '0;
			n_q       <= tpds_pkg::NUM_BARS_RESET;
			emitted_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cfg_xfer) begin
				n_q       <= n_new;
				fill_q    <= '0;
				emitted_q <= 1'b0;
			end else begin
				if (in_xfer) begin
					fill_q <= frame_done ? '0 : fill_q + 6'd1;
				end
				if (emit_start) begin
					emitted_q <= 1'b1;
				end
			end
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= last_idx)
		else $error("fill count beyond frame size");

	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q != '0) && (n_q <= tpds_pkg::NUM_BARS_MAX))
		else $error("bar count out of range");

	a_busy_no_final: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (state_q != ST_IDLE)) |-> (fill_q != last_idx))
		else $error("final bar taken while frame memories are busy");

	a_emit_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !$past(cfg_xfer)) |-> emitted_q)
		else $error("emission without emitted flag");

endmodule

`default_nettype wire

// ===== test/smoothed_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_frame_checker
// Watches the bar, result and count-write channels of the bar smoother, keeps
// its own copy of the frame state, works out every smoothed bar that an
// accepted frame should produce and compares each result transfer with it.
// ----------------------------------------------------------------------------

module smoothed_frame_checker
	import tpds_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [LEVEL_W-1:0]    s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CNT_W-1:0]      cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct {
		logic [LEVEL_W-1:0] level;
		logic [BAR_AW-1:0]  index;
		logic               last;
	} smoothed_bar_t;

	smoothed_bar_t      pending_bars[$];
	logic [CNT_W-1:0]   bar_count_reg;
	logic [LEVEL_W-1:0] loaded_levels[MAX_BARS];
	logic [LEVEL_W-1:0] shown_levels[MAX_BARS];
	int unsigned        loaded;
	bit                 shown_once;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic int unsigned bars_per_frame();
		if (bar_count_reg == 0)
			return 1;
		if (bar_count_reg > NUM_BARS_MAX)
			return MAX_BARS;
		return bar_count_reg;
	endfunction

	function automatic logic [LEVEL_W-1:0] peak_hold(logic [LEVEL_W-1:0] level,
			logic [LEVEL_W-1:0] carry);
		logic [2*LEVEL_W-1:0] product;
		logic [LEVEL_W-1:0]   decayed;
		product = 32'(carry) * 32'(DECAY_MUL);
		decayed = product[DECAY_SHIFT +: LEVEL_W];
		return level > decayed ? level : decayed;
	endfunction

	task automatic report_mismatch(string what, int unsigned want, int unsigned seen);
		$display("%0t: %s: expected %0d, got %0d", $time, what, want, seen);
		mismatches++;
	endtask

	// Stores one bar; on the final bar of a frame, smooths the frame and queues
	// the bars that will be shown, if any.
	task automatic load_bar_level(logic [LEVEL_W-1:0] level);
		int unsigned        n;
		logic [LEVEL_W-1:0] forward[MAX_BARS];
		logic [LEVEL_W-1:0] smoothed[MAX_BARS];
		logic [LEVEL_W-1:0] carry;
		bit                 changed;
		n = bars_per_frame();
		changed = 1'b0;
		if (loaded >= n)
			loaded = 0;
		loaded_levels[loaded] = level;
		loaded++;
		if (loaded < n)
			return;
		loaded = 0;
		carry = '0;
		for (int i = 0; i < n; i++) begin
			carry = peak_hold(loaded_levels[i], carry);
			forward[i] = carry;
		end
		carry = '0;
		for (int k = n - 1; k >= 0; k--) begin
			carry = peak_hold(loaded_levels[k], carry);
			smoothed[k] = forward[k] > carry ? forward[k] : carry;
		end
		for (int i = 0; i < n; i++)
			if (smoothed[i] != shown_levels[i])
				changed = 1'b1;
		if (!changed && shown_once)
			return;
		shown_once = 1'b1;
		for (int i = 0; i < n; i++) begin
			shown_levels[i] = smoothed[i];
			pending_bars.push_back('{level: smoothed[i], index: BAR_AW'(i),
				last: (i == n - 1)});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		smoothed_bar_t want;
		if (!arst_n) begin
			bar_count_reg = NUM_BARS_RESET;
			loaded = 0;
			shown_once = 1'b0;
			for (int i = 0; i < MAX_BARS; i++)
				shown_levels[i] = '0;
			pending_bars.delete();
		end else begin
			// Results are taken first: a frame completed at this edge cannot
			// already be on the output.
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_bars.size() == 0) begin
					report_mismatch("smoothed bar with none pending", 0, 1);
				end else begin
					want = pending_bars.pop_front();
					if (m_axis_tdata[LEVEL_W-1:0] != want.level)
						report_mismatch("smoothed_level", want.level,
							m_axis_tdata[LEVEL_W-1:0]);
					if (m_axis_tdata[LEVEL_W +: BAR_AW] != want.index)
						report_mismatch("bar_index", want.index,
							m_axis_tdata[LEVEL_W +: BAR_AW]);
					if (m_axis_tlast != want.last)
						report_mismatch("last_bar", want.last, m_axis_tlast);
					if (m_axis_tdata[OUT_DATA_W-1:LEVEL_W+BAR_AW] != 0)
						report_mismatch("tdata padding", 0,
							m_axis_tdata[OUT_DATA_W-1:LEVEL_W+BAR_AW]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				bar_count_reg = cfg_data;
				shown_once = 1'b0;
				loaded = 0;
			end
			if (s_axis_tvalid && s_axis_tready)
				load_bar_level(s_axis_tdata);
		end
		outstanding <= pending_bars.size();
	end

endmodule

// ===== test/two_pass_peak_decay_smoother_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_pass_peak_decay_smoother_test
// Feeds the bar smoother with frames of bar levels under a sequence of bar
// counts, including zero and oversized counts, repeated frames, dropped
// partial frames and long output stalls; a checker beside the block predicts
// and compares every smoothed bar.
// ----------------------------------------------------------------------------

module two_pass_peak_decay_smoother_test;

	import tpds_pkg::*;

	localparam int DIRECTED_ITEMS = 35;
	localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + 285;
	localparam int QUIET_ITEMS    = 60;
	localparam int DRAIN_CYCLES   = 320;
	localparam int HOLD_CYCLES    = 400;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [LEVEL_W-1:0]    s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CNT_W-1:0]      cfg_data = '0;

	int                 mismatches;
	int                 outstanding;
	int unsigned        items_sent = 0;
	bit                 quiet = 1'b0;
	bit                 hold_req = 1'b0;
	logic [LEVEL_W-1:0] last_frame[MAX_BARS];
	int unsigned        last_len = 0;

	two_pass_peak_decay_smoother i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	smoothed_frame_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("two_pass_peak_decay_smoother_test failed");
		$finish;
	end

	// Output side: random short stalls, and one long hold-off on request.
	initial begin
		int unsigned idle_left;
		int unsigned hold_left;
		idle_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_left != 0) begin
				idle_left--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				idle_left = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [LEVEL_W-1:0] random_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return LEVEL_W'($urandom_range(0, 255));
			3: return LEVEL_W'($urandom_range(0, 255)) << 8;
			default: return LEVEL_W'($urandom);
		endcase
	endfunction

	task automatic send_level(input logic [LEVEL_W-1:0] level);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= level;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		quiet = items_sent >= TOTAL_ITEMS - QUIET_ITEMS;
	endtask

	// A repeated frame smooths to the same bars, so it is shown only when the
	// count was written since the last frame shown.
	task automatic send_frame(input int unsigned n, input bit same_as_last);
		for (int i = 0; i < n; i++) begin
			if (!same_as_last)
				last_frame[i] = random_level();
			send_level(last_frame[i]);
		end
		last_len = n;
	endtask

	// A frame that shows nothing may still be in its passes, hence the settle time.
	task automatic drain(input int unsigned settle_cycles);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (settle_cycles) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] count);
		drain(DRAIN_CYCLES);
		cfg_valid <= 1'b1;
		cfg_data <= count;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned count_val;
		int unsigned n;
		int unsigned frames;
		int unsigned phase;
		int unsigned partial;
		bit          same;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One frame at the reset count with full-scale bars at both ends, an
		// isolated peak and mixed bit patterns.
		for (int i = 0; i < 32; i++) begin
			case (i)
				0, 31: last_frame[i] = 16'hFFFF;
				15: last_frame[i] = 16'h8000;
				20: last_frame[i] = 16'h0001;
				21: last_frame[i] = 16'h7FFF;
				22: last_frame[i] = 16'hAAAA;
				23: last_frame[i] = 16'h5555;
				default: last_frame[i] = '0;
			endcase
			send_level(last_frame[i]);
		end
		// A zero count acts as one bar; the same bar again shows nothing until
		// the count is written again.
		write_count(7'd0);
		last_frame[0] = 16'd7;
		last_len = 1;
		send_level(16'd7);
		send_level(16'd7);
		write_count(7'd1);
		send_level(16'd7);

		count_val = 1;
		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			case (phase)
				0: count_val = 127;
				1: count_val = 8;
				default: begin
					case ($urandom_range(0, 19))
						0: count_val = 0;
						1: count_val = $urandom_range(65, 127);
						2: count_val = 64;
						3, 4: ;
						default: count_val = $urandom_range(1, 12);
					endcase
				end
			endcase
			n = count_val == 0 ? 1 : (count_val > MAX_BARS ? MAX_BARS : count_val);
			write_count(CNT_W'(count_val));
			frames = n > 16 ? 1 : $urandom_range(2, 6);
			if (phase == 1) begin
				// Long output hold-off while frames keep coming.
				frames = 5;
				hold_req = 1'b1;
			end
			for (int f = 0; f < frames; f++) begin
				same = last_len == n && $urandom_range(0, 2) == 0;
				send_frame(n, same);
				if ((phase == 2 && f == 0) || $urandom_range(0, 9) == 0)
					drain(0);
			end
			// A partial frame is dropped by the next count write.
			if (n > 1 && $urandom_range(0, 3) == 0) begin
				partial = $urandom_range(1, n - 1);
				for (int i = 0; i < partial; i++)
					send_level(random_level());
			end
			phase++;
		end

		drain(DRAIN_CYCLES);
		if (mismatches == 0)
			$display("two_pass_peak_decay_smoother_test passed");
		else
			$display("two_pass_peak_decay_smoother_test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/tpds_pkg.sv
rtl/core/tpds_dpath.sv
rtl/core/tpds_ctrl.sv
rtl/core/two_pass_peak_decay_smoother.sv
test/smoothed_frame_checker.sv
test/two_pass_peak_decay_smoother_test.sv
